// ===== design/smm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package smm_pkg;
   localparam int MAX_ORDER = 8;
   localparam int IDX_W = $clog2(MAX_ORDER);
   localparam int ELEM_W = 16;
   localparam int PROD_W = 2 * ELEM_W;
   localparam int ACC_W = 36;
   localparam int ORDER_W = 4;
   localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(MAX_ORDER);

   localparam logic [1:0] KIND_WRITE_A = 2'd0;
   localparam logic [1:0] KIND_WRITE_B = 2'd1;
   localparam logic [1:0] KIND_COMPUTE = 2'd2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   // Data handed from one cell to the next along the chain.
   typedef struct packed {
      logic     valid;
      logic     first;
      logic     last;
      idx_type  out_row;
      idx_type  out_col;
      acc_type  acc;
   } link_type;
endpackage
`default_nettype wire

// ===== design/smm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface smm_req_if;
   import smm_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   idx_type    row;
   idx_type    col;
   elem_type   element;
   modport source (output valid, kind, row, col, element, input ready);
   modport sink (input valid, kind, row, col, element, output ready);
endinterface

interface smm_rsp_if;
   import smm_pkg::*;
   logic     valid;
   logic     ready;
   idx_type  out_row;
   idx_type  out_col;
   acc_type  product_value;
   logic     last;
   modport source (output valid, out_row, out_col, product_value, last, input ready);
   modport sink (input valid, out_row, out_col, product_value, last, output ready);
endinterface

interface smm_csr_if;
   import smm_pkg::*;
   logic               valid;
   logic               ready;
   logic [ORDER_W-1:0] order;
   modport source (output valid, order, input ready);
   modport sink (input valid, order, output ready);
endinterface
`default_nettype wire

// ===== design/smm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smm_cell
   import smm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire logic     active,
   input  wire elem_type a_value,
   input  wire elem_type b_value,
   input  wire link_type link_in,
   output link_type      link_out
);
   link_type link_ff;
   logic signed [PROD_W-1:0] prod;
   acc_type base;

   // Each active cell adds one product term; the first cell of a chain starts at zero.
   assign prod = a_value * b_value;
   assign base = link_in.first ? '0 : link_in.acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else if (advance) begin
         link_ff.valid <= link_in.valid;
      end
      if (advance) begin
         link_ff.first   <= 1'b0;
         link_ff.last    <= link_in.last;
         link_ff.out_row <= link_in.out_row;
         link_ff.out_col <= link_in.out_col;
         link_ff.acc     <= active ? base + ACC_W'(prod) : base;
      end
   end

   assign link_out = link_ff;
endmodule
`default_nettype wire

// ===== design/square_matrix_multiply.sv =====
// Channel  Direction  Carries
// req      in         kind, row, col, element
// rsp      out        out_row, out_col, product_value, last
// csr      in         order
//
// A compute request starts a sequencer that walks the result elements in
// row-major order; the element is built in a chain of MAX_ORDER cells, cell k
// adding A[i][k]*B[k][j] for k below the order, so one result leaves per cycle
// while rsp is taken, passing the cell registers and then the output register.
// The chain stalls as a whole while rsp is not taken. Reset clears control
// state only; matrices are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module square_matrix_multiply
   import smm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   smm_req_if.sink   req,
   smm_rsp_if.source rsp,
   smm_csr_if.sink   csr
);
   localparam int CNT_W = $clog2(MAX_ORDER + 2);

   logic [ORDER_W-1:0] order_ff;
   logic [1:0]         state_ff, state_in;
   idx_type            i_ff, i_in, j_ff, j_in;
   logic [CNT_W-1:0]   drain_ff, drain_in;
   logic [ORDER_W-1:0] n_eff;
   idx_type            n_last;
   logic               advance, issue, done_issue;
   logic               write_ok;
   link_type           chain [MAX_ORDER+1];
   // Skewed operand indices: cell k takes i, j from the link that enters it.
   idx_type            row_d [MAX_ORDER];
   idx_type            col_d [MAX_ORDER];
   logic               rsp_valid_ff;
   link_type           out_ff;

   always_comb begin
      if (order_ff == '0) n_eff = ORDER_W'(1);
      else if (order_ff > ORDER_W'(MAX_ORDER)) n_eff = ORDER_W'(MAX_ORDER);
      else n_eff = order_ff;
   end
   assign n_last = IDX_W'(n_eff - ORDER_W'(1));

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
      end else if (csr.valid) begin
         order_ff <= csr.order;
      end
   end

   // Chain moves whenever the output register is free or being emptied.
   assign advance = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);

   // An element write lands only inside the active block.
   assign write_ok = req.valid && req.ready && {1'b0, req.row} < n_eff
                     && {1'b0, req.col} < n_eff;

   // Sequencer over result elements, then a drain of the chain.
   assign issue = (state_ff == ST_RUN) && (drain_ff == '0) && advance;
   assign done_issue = issue && i_ff == n_last && j_ff == n_last;
   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      j_in = j_ff;
      drain_in = drain_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.kind == KIND_COMPUTE) begin
               state_in = ST_RUN;
               i_in = '0;
               j_in = '0;
               drain_in = '0;
            end
         end
         ST_RUN: begin
            if (drain_ff != '0) begin
               if (advance) begin
                  if (drain_ff == CNT_W'(1)) state_in = ST_IDLE;
                  drain_in = drain_ff - CNT_W'(1);
               end
            end else if (issue) begin
               if (done_issue) begin
                  drain_in = CNT_W'(MAX_ORDER + 1);
               end else if (j_ff == n_last) begin
                  j_in = '0;
                  i_in = i_ff + IDX_W'(1);
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
   end

   // Chain head.
   always_comb begin
      chain[0].valid = issue;
      chain[0].first = 1'b1;
      chain[0].last = done_issue;
      chain[0].out_row = i_ff;
      chain[0].out_col = j_ff;
      chain[0].acc = '0;
   end

   for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
      logic active;
      // Column k of A, indexed by row, and row k of B, indexed by column.
      elem_type a_col_ff [MAX_ORDER];
      elem_type b_row_ff [MAX_ORDER];

      always_ff @(posedge clock) begin
         if (write_ok && req.kind == KIND_WRITE_A && req.col == IDX_W'(k))
            a_col_ff[req.row] <= req.element;
         if (write_ok && req.kind == KIND_WRITE_B && req.row == IDX_W'(k))
            b_row_ff[req.col] <= req.element;
      end

      if (k == 0) begin : g_d0
         assign row_d[k] = i_ff;
         assign col_d[k] = j_ff;
      end else begin : g_dk
         assign row_d[k] = chain[k].out_row;
         assign col_d[k] = chain[k].out_col;
      end
      assign active = ORDER_W'(k) < n_eff;
      smm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .active  (active),
         .a_value (a_col_ff[row_d[k]]),
         .b_value (b_row_ff[col_d[k]]),
         .link_in (chain[k]),
         .link_out(chain[k+1])
      );
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain[MAX_ORDER].valid;
      end
      if (advance) out_ff <= chain[MAX_ORDER];
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_row = out_ff.out_row;
   assign rsp.out_col = out_ff.out_col;
   assign rsp.product_value = out_ff.acc;
   assign rsp.last = out_ff.last;
endmodule
`default_nettype wire

// ===== design/smm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module smm_checker
   import smm_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_last,
   input wire logic [IDX_W-1:0] rsp_out_row,
   input wire logic [IDX_W-1:0] rsp_out_col
);
   // A stalled result holds its position.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_row)
      && $stable(rsp_out_col))
      else $error("stalled result changed");

   // A result after the last one starts at the top-left corner.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid
      || (rsp_out_row == '0 && rsp_out_col == '0))
      else $error("run did not restart at origin");

   // Requests are not taken while results are still leaving.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken during a run");

   // After reset no result is shown.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind square_matrix_multiply smm_checker u_smm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_last   (rsp.last),
   .rsp_out_row(rsp.out_row),
   .rsp_out_col(rsp.out_col)
);
`default_nettype wire
